[hw/rtl/mss_pkg.sv]
// mss_pkg: shared widths, item codes, payload types and the controller/datapath
// command and status structs of the multilevel sjf scheduler
// no dependencies
package mss_pkg;

  localparam int unsigned JOB_W   = 8;
  localparam int unsigned BURST_W = 8;
  localparam int unsigned PRIO_W  = 2;
  localparam int unsigned RLVL_W  = 2;
  localparam int unsigned RPT_W   = 16;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [JOB_W-1:0]   job_id;
    logic [PRIO_W-1:0]  priority_req;
    logic [BURST_W-1:0] burst;
  } mss_in_t;

  typedef struct packed {
    logic              accepted;
    logic              ran;
    logic [JOB_W-1:0]  run_job;
    logic [RLVL_W-1:0] run_level;
    logic              finished;
    logic [RPT_W-1:0]  turnaround;
    logic [RPT_W-1:0]  response;
  } mss_out_t;

  typedef struct packed {
    logic load_in;
    logic do_arrive;
    logic scan_start;
    logic scan_step;
    logic rd_run;
    logic exec_run;
    logic exec_idle;
  } mss_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic need_sel;
    logic scan_done;
    logic found;
    logic out_free;
  } mss_sts_t;

endpackage

[hw/rtl/mss_if.sv]
// mss_in_if and mss_out_if: valid/ready channels of the scheduler
// depends on mss_pkg
interface mss_in_if
  import mss_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [JOB_W-1:0]   job_id;
  logic [PRIO_W-1:0]  priority_req;
  logic [BURST_W-1:0] burst;

  modport source (output valid, output kind, output job_id, output priority_req,
                  output burst, input ready);
  modport sink (input valid, input kind, input job_id, input priority_req,
                input burst, output ready);
endinterface

interface mss_out_if
  import mss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              ran;
  logic [JOB_W-1:0]  run_job;
  logic [RLVL_W-1:0] run_level;
  logic              finished;
  logic [RPT_W-1:0]  turnaround;
  logic [RPT_W-1:0]  response;

  modport source (output valid, output accepted, output ran, output run_job,
                  output run_level, output finished, output turnaround,
                  output response, input ready);
  modport sink (input valid, input accepted, input ran, input run_job,
                input run_level, input finished, input turnaround,
                input response, output ready);
endinterface

[hw/rtl/mss_ctrl.sv]
// mss_ctrl: sequencing state machine of the scheduler
// depends on mss_pkg; drives mss_dpath through command and status structs
module mss_ctrl
  import mss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mss_sts_t sts_i,
  output mss_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EXE   = 3'd4;
  localparam logic [2:0] S_IDLET = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts_i.in_tick) begin
          if (sts_i.out_free) begin
            cmd_o.do_arrive = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (sts_i.need_sel) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          state_d = S_RD;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.found ? S_RD : S_IDLET;
        end
      end
      S_RD: begin
        cmd_o.rd_run = 1'b1;
        state_d      = S_EXE;
      end
      S_EXE: begin
        if (sts_i.out_free) begin
          cmd_o.exec_run = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_IDLET: begin
        if (sts_i.out_free) begin
          cmd_o.exec_idle = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/mss_dpath.sv]
// mss_dpath: slot memory, level counts, time, selection scan and result register
// depends on mss_pkg; sequenced by mss_ctrl
module mss_dpath
  import mss_pkg::*;
#(
  parameter int unsigned SLOTS_PER_LEVEL = 16,
  parameter int unsigned LEVELS          = 3,
  parameter int unsigned TIME_BITS       = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mss_in_t  in_item_i,
  input  mss_cmd_t cmd_i,
  output mss_sts_t sts_o,
  output mss_out_t out_item_o,
  output logic     out_valid_o,
  input  logic     out_ready_i
);

  localparam int unsigned SW    = $clog2(SLOTS_PER_LEVEL);
  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned AW    = LW + SW;
  localparam int unsigned DEPTH = LEVELS << SW;

  typedef struct packed {
    logic [JOB_W-1:0]     job;
    logic [BURST_W-1:0]   burst;
    logic [BURST_W-1:0]   rem;
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] first;
  } slot_t;

  function automatic logic [RPT_W-1:0] sat_rpt(input logic [TIME_BITS-1:0] v);
    logic [TIME_BITS+RPT_W-1:0] w;
    w = (TIME_BITS + RPT_W)'(v);
    return ((w >> RPT_W) != '0) ? '1 : w[RPT_W-1:0];
  endfunction

  slot_t mem_q [0:DEPTH-1];
  slot_t rd_data_q;
  slot_t wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  mss_in_t              item_q;
  logic [SW:0]          level_cnt_q [LEVELS];
  logic [TIME_BITS-1:0] time_q, t_next;
  logic                 run_valid_q, resel_q;
  logic [LW-1:0]        run_lv_q;
  logic [SW-1:0]        run_slot_q;

  logic [LW-1:0]        scan_lv_q;
  logic [SW:0]          scan_s_q;
  logic                 rd_pend_q, found_q;
  logic [SW-1:0]        rd_slot_q, best_slot_q;
  logic [BURST_W-1:0]   best_burst_q;

  mss_out_t out_q, out_d;
  logic     out_valid_q;

  logic [LW-1:0]     arr_lv, cnt_lv;
  logic [SW:0]       cnt_rd;
  logic              full, scan_issue, level_end, scan_done, cand_hit;
  logic [BURST_W-1:0] rem_n;
  logic [TIME_BITS-1:0] first_n;
  logic [LW+1:0]     lv_ext;

  // level from priority, out-of-range codes go to the last (lowest-priority) level
  always_comb begin
    if (item_q.priority_req != '0 && 32'(item_q.priority_req) <= LEVELS - 1) begin
      arr_lv = LW'(32'(item_q.priority_req) - 1);
    end else begin
      arr_lv = LW'(LEVELS - 1);
    end
  end

  assign cnt_lv     = cmd_i.do_arrive ? arr_lv : scan_lv_q;
  assign cnt_rd     = level_cnt_q[cnt_lv];
  assign full       = cnt_rd >= (SW + 1)'(SLOTS_PER_LEVEL);
  assign scan_issue = scan_s_q < cnt_rd;
  assign level_end  = !scan_issue && !rd_pend_q;
  assign scan_done  = level_end && (found_q || scan_lv_q == LW'(LEVELS - 1));
  assign cand_hit   = rd_pend_q && rd_data_q.rem != '0 &&
                      (!found_q || rd_data_q.burst < best_burst_q);

  assign t_next  = (time_q == '1) ? time_q : time_q + 1'b1;
  assign rem_n   = rd_data_q.rem - 1'b1;
  assign first_n = (rd_data_q.rem == rd_data_q.burst) ? time_q : rd_data_q.first;
  assign lv_ext  = (LW + 2)'(run_lv_q);

  // memory ports
  assign rd_addr = cmd_i.scan_step ? {scan_lv_q, scan_s_q[SW-1:0]} : {run_lv_q, run_slot_q};
  assign wr_en   = (cmd_i.do_arrive && !full) || cmd_i.exec_run;

  always_comb begin
    if (cmd_i.do_arrive) begin
      wr_addr = {arr_lv, cnt_rd[SW-1:0]};
      wr_data = '{job: item_q.job_id, burst: item_q.burst, rem: item_q.burst,
                  arrival: time_q, first: '0};
    end else begin
      wr_addr = {run_lv_q, run_slot_q};
      wr_data = '{job: rd_data_q.job, burst: rd_data_q.burst, rem: rem_n,
                  arrival: rd_data_q.arrival, first: first_n};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if ((cmd_i.scan_step && scan_issue) || cmd_i.rd_run) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // result for the item in hand
  always_comb begin
    out_d = out_q;
    if (cmd_i.do_arrive) begin
      out_d          = '0;
      out_d.accepted = !full;
    end else if (cmd_i.exec_idle) begin
      out_d = '0;
    end else if (cmd_i.exec_run) begin
      out_d           = '0;
      out_d.ran       = 1'b1;
      out_d.run_job   = rd_data_q.job;
      out_d.run_level = lv_ext[RLVL_W-1:0];
      if (rem_n == '0) begin
        out_d.finished   = 1'b1;
        out_d.turnaround = sat_rpt(t_next - rd_data_q.arrival);
        out_d.response   = sat_rpt(first_n - rd_data_q.arrival);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_item_i;
    end
    if (cmd_i.scan_step && scan_issue) begin
      rd_slot_q <= scan_s_q[SW-1:0];
    end
    if (cmd_i.scan_step && cand_hit) begin
      best_burst_q <= rd_data_q.burst;
      best_slot_q  <= rd_slot_q;
    end
    out_q <= out_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        level_cnt_q[i] <= '0;
      end
      time_q      <= '0;
      run_valid_q <= 1'b0;
      run_lv_q    <= '0;
      run_slot_q  <= '0;
      resel_q     <= 1'b1;
      scan_lv_q   <= '0;
      scan_s_q    <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.do_arrive && !full) begin
        level_cnt_q[arr_lv] <= cnt_rd + 1'b1;
        if (!run_valid_q || arr_lv <= run_lv_q) begin
          resel_q <= 1'b1;
        end
      end
      if (cmd_i.scan_start) begin
        scan_lv_q <= '0;
        scan_s_q  <= '0;
        rd_pend_q <= 1'b0;
        found_q   <= 1'b0;
        resel_q   <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (cand_hit) begin
          found_q <= 1'b1;
        end
        rd_pend_q <= scan_issue;
        if (scan_issue) begin
          scan_s_q <= scan_s_q + 1'b1;
        end else if (scan_done) begin
          run_valid_q <= found_q;
          run_lv_q    <= found_q ? scan_lv_q : '0;
          run_slot_q  <= found_q ? best_slot_q : '0;
        end else if (level_end) begin
          scan_lv_q <= scan_lv_q + 1'b1;
          scan_s_q  <= '0;
        end
      end
      if (cmd_i.exec_run || cmd_i.exec_idle) begin
        time_q <= t_next;
      end
      if (cmd_i.exec_run && rem_n == '0) begin
        run_valid_q <= 1'b0;
        resel_q     <= 1'b1;
      end
      if (cmd_i.do_arrive || cmd_i.exec_run || cmd_i.exec_idle) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.in_tick   = item_q.kind == KIND_TICK;
  assign sts_o.need_sel  = resel_q || !run_valid_q;
  assign sts_o.scan_done = scan_done;
  assign sts_o.found     = found_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/multilevel_sjf_scheduler_unit.sv]
// multilevel_sjf_scheduler_unit: top level of the three-level preemptive sjf scheduler
// depends on mss_pkg, mss_if, mss_ctrl and mss_dpath
//
//   channel | dir | transfer contents
//   job_i   | in  | kind, job_id, priority_req, burst
//   res_o   | out | accepted, ran, run_job, run_level, finished, turnaround, response
//
// one item at a time; an arrive passes through load and dispatch, a tick without
// reselection through load, dispatch, slot read and execute; a tick with reselection
// adds a serial scan of the slot memory over the stored slots of each level visited,
// up to the first level holding an unfinished job (one read port of the slot memory
// sets this)
// a result waits in an output register; the next item is taken meanwhile and
// stalls at its own result until res_o is free
// reset clears the level counts, time and selection at once; no clearing pass
module multilevel_sjf_scheduler_unit
  import mss_pkg::*;
#(
  parameter int unsigned SLOTS_PER_LEVEL = 16,
  parameter int unsigned LEVELS          = 3,
  parameter int unsigned TIME_BITS       = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mss_in_if.sink    job_i,
  mss_out_if.source res_o
);

  mss_cmd_t cmd;
  mss_sts_t sts;
  mss_in_t  in_item;
  mss_out_t out_item;

  assign in_item = '{kind: job_i.kind, job_id: job_i.job_id,
                     priority_req: job_i.priority_req, burst: job_i.burst};

  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (job_i.valid),
    .in_ready_o (job_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mss_dpath #(
    .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
    .LEVELS          (LEVELS),
    .TIME_BITS       (TIME_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready)
  );

  assign res_o.accepted   = out_item.accepted;
  assign res_o.ran        = out_item.ran;
  assign res_o.run_job    = out_item.run_job;
  assign res_o.run_level  = out_item.run_level;
  assign res_o.finished   = out_item.finished;
  assign res_o.turnaround = out_item.turnaround;
  assign res_o.response   = out_item.response;

endmodule

[hw/rtl/mss_checker.sv]
// mss_checker: port-level assertions of the scheduler and their bind
// depends on mss_pkg; attached to multilevel_sjf_scheduler_unit
module mss_checker
  import mss_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              accepted_i,
  input logic              ran_i,
  input logic [JOB_W-1:0]  run_job_i,
  input logic [RLVL_W-1:0] run_level_i,
  input logic              finished_i,
  input logic [RPT_W-1:0]  turnaround_i,
  input logic [RPT_W-1:0]  response_i
);

  // a waiting result stays valid with run_job and turnaround unchanged until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(run_job_i) &&
    $stable(turnaround_i))
    else $error("result changed while stalled");

  a_arrive_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && accepted_i |-> !ran_i && !finished_i)
    else $error("arrive result shows a run");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ran_i |-> run_job_i == '0 && run_level_i == '0 && !finished_i)
    else $error("idle result not cleared");

  a_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !finished_i |-> turnaround_i == '0 && response_i == '0)
    else $error("report without completion");

  a_resp_le_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && finished_i |-> response_i <= turnaround_i)
    else $error("response exceeds turnaround");

endmodule

bind multilevel_sjf_scheduler_unit mss_checker u_mss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .accepted_i   (res_o.accepted),
  .ran_i        (res_o.ran),
  .run_job_i    (res_o.run_job),
  .run_level_i  (res_o.run_level),
  .finished_i   (res_o.finished),
  .turnaround_i (res_o.turnaround),
  .response_i   (res_o.response)
);

[tb/multilevel_sjf_scheduler_unit_tb.sv]
// multilevel_sjf_scheduler_unit_tb: self-checking bench for the three-level sjf scheduler
// drives job_i, checks every res_o transfer against a directed row's typed outcome or an in-bench scheduler model
// depends on mss_pkg, mss_if and multilevel_sjf_scheduler_unit
module multilevel_sjf_scheduler_unit_tb;
  import mss_pkg::*;

  localparam int LEVELS  = 3;
  localparam int SLOTS   = 16;
  localparam int RAND_N  = 1000;
  localparam int DIR_N   = 21;

  typedef struct packed {
    mss_in_t  item;
    logic     typed;
    mss_out_t want;
  } dir_row_t;

  localparam mss_out_t TOOK = '{1'b1, 1'b0, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0};
  localparam mss_out_t NONE = '0;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b1, NONE},
    '{'{KIND_ARRIVE, 8'h00, 2'd1, 8'd1},   1'b1, TOOK},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b1,
      '{1'b0, 1'b1, 8'h00, 2'd0, 1'b1, 16'd1, 16'd0}},
    '{'{KIND_ARRIVE, 8'hff, 2'd3, 8'd255}, 1'b1, TOOK},
    '{'{KIND_ARRIVE, 8'haa, 2'd2, 8'd3},   1'b0, NONE},
    '{'{KIND_ARRIVE, 8'h55, 2'd2, 8'd2},   1'b0, NONE},
    '{'{KIND_ARRIVE, 8'h11, 2'd2, 8'd2},   1'b0, NONE},
    '{'{KIND_TICK,   8'hff, 2'd3, 8'hff},  1'b0, NONE},
    '{'{KIND_ARRIVE, 8'h22, 2'd0, 8'd7},   1'b1, TOOK},
    '{'{KIND_ARRIVE, 8'h33, 2'd2, 8'd0},   1'b1, TOOK},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b0, NONE},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b0, NONE},
    '{'{KIND_ARRIVE, 8'h44, 2'd1, 8'd4},   1'b0, NONE},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b0, NONE},
    '{'{KIND_ARRIVE, 8'h66, 2'd1, 8'd4},   1'b0, NONE},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b0, NONE},
    '{'{KIND_ARRIVE, 8'h77, 2'd3, 8'd1},   1'b0, NONE},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b0, NONE},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b0, NONE},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b0, NONE},
    '{'{KIND_TICK,   8'h00, 2'd0, 8'd0},   1'b0, NONE}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sink_ready = 1'b0;
  bit   quiet_run = 1'b1;
  int   err_count = 0;

  mss_out_t pending_outcomes [$];

  // scheduler model state
  bit        slot_used  [LEVELS][SLOTS];
  bit [7:0]  slot_id    [LEVELS][SLOTS];
  bit [7:0]  slot_len   [LEVELS][SLOTS];
  bit [7:0]  slot_left  [LEVELS][SLOTS];
  bit [15:0] slot_arr   [LEVELS][SLOTS];
  bit [15:0] slot_start [LEVELS][SLOTS];
  int        level_fill [LEVELS];
  bit [15:0] clock_now;
  bit        cur_valid;
  int        cur_level;
  int        cur_slot;
  bit        resel_pending = 1'b1;

  mss_in_if  job_if ();
  mss_out_if res_if ();

  assign res_if.ready = sink_ready;

  multilevel_sjf_scheduler_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic mss_out_t run_scheduler(mss_in_t it);
    mss_out_t res;
    int lv;
    int s;
    bit found;
    res = '0;
    if (it.kind == KIND_ARRIVE) begin
      lv = (it.priority_req >= 1 && it.priority_req <= LEVELS - 1) ?
           int'(it.priority_req) - 1 : LEVELS - 1;
      if (level_fill[lv] >= SLOTS) return res;
      s = level_fill[lv];
      slot_used[lv][s]  = 1'b1;
      slot_id[lv][s]    = it.job_id;
      slot_len[lv][s]   = it.burst;
      slot_left[lv][s]  = it.burst;
      slot_arr[lv][s]   = clock_now;
      slot_start[lv][s] = '0;
      level_fill[lv]++;
      if (!cur_valid || lv <= cur_level) resel_pending = 1'b1;
      res.accepted = 1'b1;
      return res;
    end
    if (resel_pending || !cur_valid || slot_left[cur_level][cur_slot] == 0) begin
      found = 1'b0;
      for (lv = 0; lv < LEVELS && !found; lv++) begin
        for (s = 0; s < level_fill[lv]; s++) begin
          if (slot_used[lv][s] && slot_left[lv][s] != 0 &&
              (!found || slot_len[lv][s] < slot_len[lv][cur_slot])) begin
            found     = 1'b1;
            cur_level = lv;
            cur_slot  = s;
          end
        end
      end
      cur_valid = found;
      if (!found) begin
        cur_level = 0;
        cur_slot  = 0;
      end
      resel_pending = 1'b0;
    end
    if (!cur_valid) begin
      if (clock_now != '1) clock_now++;
      return res;
    end
    if (slot_left[cur_level][cur_slot] == slot_len[cur_level][cur_slot])
      slot_start[cur_level][cur_slot] = clock_now;
    slot_left[cur_level][cur_slot]--;
    if (clock_now != '1) clock_now++;
    res.ran       = 1'b1;
    res.run_job   = slot_id[cur_level][cur_slot];
    res.run_level = RLVL_W'(cur_level);
    if (slot_left[cur_level][cur_slot] == 0) begin
      res.finished   = 1'b1;
      res.turnaround = clock_now - slot_arr[cur_level][cur_slot];
      res.response   = slot_start[cur_level][cur_slot] - slot_arr[cur_level][cur_slot];
      cur_valid      = 1'b0;
      resel_pending  = 1'b1;
    end
    return res;
  endfunction

  task automatic offer_item(mss_in_t it, logic typed, mss_out_t want);
    mss_out_t modelled;
    if (!quiet_run) begin
      while ($urandom_range(99) < 19) begin
        job_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    job_if.valid        <= 1'b1;
    job_if.kind         <= it.kind;
    job_if.job_id       <= it.job_id;
    job_if.priority_req <= it.priority_req;
    job_if.burst        <= it.burst;
    @(posedge clk_i);
    while (!job_if.ready) @(posedge clk_i);
    modelled = run_scheduler(it);
    pending_outcomes.push_back(typed ? want : modelled);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    mss_out_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("res_o transfer with no outcome pending");
        err_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("accepted", 16'(want.accepted), 16'(res_if.accepted));
        check_field("ran", 16'(want.ran), 16'(res_if.ran));
        check_field("run_job", 16'(want.run_job), 16'(res_if.run_job));
        check_field("run_level", 16'(want.run_level), 16'(res_if.run_level));
        check_field("finished", 16'(want.finished), 16'(res_if.finished));
        check_field("turnaround", want.turnaround, res_if.turnaround);
        check_field("response", want.response, res_if.response);
      end
    end
    sink_ready <= quiet_run || ($urandom_range(99) >= 19);
  end

  initial begin
    mss_in_t it;
    int i;
    int r;
    int guard;
    job_if.valid        = 1'b0;
    job_if.kind         = KIND_TICK;
    job_if.job_id       = '0;
    job_if.priority_req = '0;
    job_if.burst        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    quiet_run = 1'b0;

    for (i = 0; i < DIR_N; i++)
      offer_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    // mostly ticks with sparse arrivals so the tables fill part way through
    for (i = 0; i < RAND_N; i++) begin
      quiet_run = (i >= 200 && i < 350);
      it.kind   = ($urandom_range(99) < 14) ? KIND_ARRIVE : KIND_TICK;
      it.job_id = 8'($urandom_range(255));
      r = $urandom_range(99);
      it.priority_req = (r < 3) ? 2'd0 : 2'($urandom_range(3, 1));
      r = $urandom_range(99);
      if (r < 2)       it.burst = 8'd0;
      else if (r < 80) it.burst = 8'($urandom_range(10, 1));
      else if (r < 95) it.burst = 8'($urandom_range(64, 11));
      else             it.burst = 8'($urandom_range(255, 65));
      offer_item(it, 1'b0, NONE);
    end
    quiet_run = 1'b0;
    job_if.valid <= 1'b0;

    guard = 0;
    while (pending_outcomes.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      $error("%0d outcomes never transferred", pending_outcomes.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("multilevel_sjf_scheduler_unit verification clean");
    end else begin
      $display("multilevel_sjf_scheduler_unit verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("multilevel_sjf_scheduler_unit verification failed");
    $finish;
  end

endmodule
